>>> rtl/core/pid_position_clamped_integral_core_macros.svh
// assertion macros for the pid position core
`ifndef PID_POSITION_CLAMPED_INTEGRAL_CORE_MACROS_SVH
`define PID_POSITION_CLAMPED_INTEGRAL_CORE_MACROS_SVH

// consequent checked in the same cycle
`define PCIC_CHECK_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcic same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define PCIC_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcic next-cycle check failed");

`endif

>>> rtl/core/pcic_pkg.sv
// shared constants and types for the pid position core
package pcic_pkg;

   localparam int DATA_WIDTH_DEF     = 24;
   localparam int GAIN_FRAC_BITS_DEF = 8;
   localparam int GAIN_W             = 16;
   localparam int LIMIT_W            = 23;
   localparam int INTEG_W            = LIMIT_W + 1;
   localparam int DRIVE_W            = 32;
   localparam int CSR_DATA_W         = 23;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd563;
   localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd0;
   localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd3072;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd25600;

   // item function codes
   localparam logic FUNC_STEP  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      CSR_KP    = 2'd0,
      CSR_KI    = 2'd1,
      CSR_KD    = 2'd2,
      CSR_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  kp;
      logic [GAIN_W-1:0]  ki;
      logic [GAIN_W-1:0]  kd;
      logic [LIMIT_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic                      advance;
      logic                      out_clear;
      logic signed [INTEG_W-1:0] integral;
   } back_status_type;

endpackage

>>> rtl/core/pcic_if.sv
// request and response channel interfaces
interface pcic_req_if #(
   parameter int DATA_WIDTH = pcic_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic signed [DATA_WIDTH-1:0] setpoint;
   logic signed [DATA_WIDTH-1:0] measurement;

   modport source (output valid, func, setpoint, measurement, input ready);
   modport sink   (input valid, func, setpoint, measurement, output ready);
endinterface

interface pcic_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pcic_pkg::DRIVE_W-1:0]   drive;

   modport source (output valid, drive, input ready);
   modport sink   (input valid, drive, output ready);
endinterface

>>> rtl/core/pcic_queue.sv
// small register queue between front and back
module pcic_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pcic_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   input  logic             pop
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/pcic_front.sv
// front end: takes items, forms error and error change
module pcic_front #(
   parameter int DATA_WIDTH = pcic_pkg::DATA_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   pcic_req_if.sink                 req,
   input  logic                     q_full,
   output logic                     q_push,
   output logic [2*DATA_WIDTH+3:0]  q_data
);
   import pcic_pkg::*;

   localparam int EW  = DATA_WIDTH + 1;
   localparam int DFW = DATA_WIDTH + 2;

   logic signed [EW-1:0]  prev_err_ff, prev_err_in;
   logic signed [EW-1:0]  err;
   logic signed [DFW-1:0] diff;
   logic                  is_clear;
   logic                  xfer;

   assign req.ready = !q_full;
   assign xfer      = req.valid && req.ready;
   assign is_clear  = (req.func == FUNC_CLEAR);

   // error and change of error
   assign err  = EW'(req.setpoint) - EW'(req.measurement);
   assign diff = DFW'(err) - DFW'(prev_err_ff);

   assign q_push = xfer;
   assign q_data = {req.func, err, diff};

   // last error, cleared by a clear item
   always_comb begin
      prev_err_in = prev_err_ff;
      if (xfer) begin
         prev_err_in = is_clear ? '0 : err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
      end else begin
         prev_err_ff <= prev_err_in;
      end
   end

endmodule

>>> rtl/core/pcic_back.sv
// back end: gain products, integral clamp, drive sum and saturation
module pcic_back #(
   parameter int DATA_WIDTH     = pcic_pkg::DATA_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = pcic_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pcic_pkg::cfg_type           cfg,
   input  logic                        q_valid,
   input  logic [2*DATA_WIDTH+3:0]     q_data,
   output logic                        q_pop,
   pcic_rsp_if.source                  rsp,
   output pcic_pkg::back_status_type   status
);
   import pcic_pkg::*;

   localparam int F   = GAIN_FRAC_BITS;
   localparam int EW  = DATA_WIDTH + 1;
   localparam int DFW = DATA_WIDTH + 2;
   localparam int GW  = GAIN_W + 1;
   localparam int PPW = GW + EW;
   localparam int DPW = GW + DFW;
   localparam int SPW = PPW - F;
   localparam int SDW = DPW - F;
   localparam int AW  = ((SPW > INTEG_W) ? SPW : INTEG_W) + 1;
   localparam int PDW = SDW + 1;
   localparam int TW  = ((PDW > INTEG_W) ? PDW : INTEG_W) + 1;
   localparam int SW  = (TW > DRIVE_W + 1) ? TW : DRIVE_W + 1;
   localparam logic signed [SW-1:0] DRIVE_MAX = {{(SW-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
   localparam logic signed [SW-1:0] DRIVE_MIN = {{(SW-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

   logic                  advance;
   logic                  head_func;
   logic signed [EW-1:0]  head_err;
   logic signed [DFW-1:0] head_diff;

   // stage one: products
   logic                  s1_valid_ff;
   logic                  s1_func_ff;
   logic signed [PPW-1:0] prod_p_ff, prod_i_ff;
   logic signed [DPW-1:0] prod_d_ff;
   logic signed [PPW-1:0] prod_p_in, prod_i_in;
   logic signed [DPW-1:0] prod_d_in;

   // stage two: integral and partial drive
   logic                      s2_valid_ff;
   logic                      s2_func_ff;
   logic signed [INTEG_W-1:0] integral_ff, integral_in;
   logic signed [PDW-1:0]     pd_ff, pd_in;
   logic signed [SPW-1:0]     sc_p, sc_i;
   logic signed [SDW-1:0]     sc_d;
   logic signed [AW-1:0]      acc, lim_pos, lim_neg;

   // output register
   logic                      out_valid_ff;
   logic                      out_clear_ff;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;
   logic signed [TW-1:0]      total;
   logic signed [SW-1:0]      total_ext;

   assign advance = !out_valid_ff || rsp.ready;
   assign q_pop   = advance && q_valid;

   assign {head_func, head_err, head_diff} = q_data;

   // gain products, gains taken as positive signed values
   assign prod_p_in = PPW'(signed'({1'b0, cfg.kp})) * PPW'(head_err);
   assign prod_i_in = PPW'(signed'({1'b0, cfg.ki})) * PPW'(head_err);
   assign prod_d_in = DPW'(signed'({1'b0, cfg.kd})) * DPW'(head_diff);

   // floor scaling is dropping the fraction bits
   assign sc_p = prod_p_ff[PPW-1:F];
   assign sc_i = prod_i_ff[PPW-1:F];
   assign sc_d = prod_d_ff[DPW-1:F];

   // integral update with symmetric clamp
   assign acc     = AW'(integral_ff) + AW'(sc_i);
   assign lim_pos = AW'({1'b0, cfg.limit});
   assign lim_neg = -lim_pos;

   always_comb begin
      integral_in = integral_ff;
      if (advance && s1_valid_ff) begin
         if (s1_func_ff == FUNC_CLEAR) begin
            integral_in = '0;
         end else if (acc > lim_pos) begin
            integral_in = INTEG_W'(lim_pos);
         end else if (acc < lim_neg) begin
            integral_in = INTEG_W'(lim_neg);
         end else begin
            integral_in = INTEG_W'(acc);
         end
      end
   end

   assign pd_in = PDW'(sc_p) + PDW'(sc_d);

   // final sum and saturation, zero drive for a clear item
   assign total     = TW'(pd_ff) + TW'(integral_ff);
   assign total_ext = SW'(total);

   always_comb begin
      if (s2_func_ff == FUNC_CLEAR) begin
         drive_in = '0;
      end else if (total_ext > DRIVE_MAX) begin
         drive_in = DRIVE_MAX[DRIVE_W-1:0];
      end else if (total_ext < DRIVE_MIN) begin
         drive_in = DRIVE_MIN[DRIVE_W-1:0];
      end else begin
         drive_in = total_ext[DRIVE_W-1:0];
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         integral_ff  <= '0;
      end else begin
         integral_ff <= integral_in;
         if (advance) begin
            s1_valid_ff  <= q_valid;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_func_ff   <= head_func;
         prod_p_ff    <= prod_p_in;
         prod_i_ff    <= prod_i_in;
         prod_d_ff    <= prod_d_in;
         s2_func_ff   <= s1_func_ff;
         pd_ff        <= pd_in;
         out_clear_ff <= s2_func_ff;
         drive_ff     <= drive_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.drive = drive_ff;

   assign status.advance   = advance;
   assign status.out_clear = out_clear_ff;
   assign status.integral  = integral_ff;

endmodule

>>> rtl/core/pid_position_clamped_integral_core.sv
// top level of the positional pid core with clamped integral
//
//   channel | dir | transfer when          | payload
//   --------+-----+------------------------+--------------------------------
//   req     | in  | req.valid & req.ready  | func, setpoint, measurement
//   rsp     | out | rsp.valid & rsp.ready  | drive
//   csr     | in  | csr_wr_en              | csr_index, csr_wdata
//
// one item per cycle sustained while rsp.ready holds high; after its transfer a result passes
// through the queue, product stage, integral stage and output register.
// the integral add-and-clamp loop in the back end sets the item step.
// reset is synchronous: gains and limit take their defaults, state and valids clear.
// rsp.ready low with a result held freezes the back end; the two-entry queue then fills and drops req.ready.
`include "pid_position_clamped_integral_core_macros.svh"

module pid_position_clamped_integral_core #(
   parameter int DATA_WIDTH     = pcic_pkg::DATA_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = pcic_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   pcic_req_if.sink                            req,
   pcic_rsp_if.source                          rsp,
   input  logic                                csr_wr_en,
   input  pcic_pkg::csr_index_type             csr_index,
   input  logic [pcic_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pcic_pkg::*;

   localparam int QW = 2 * DATA_WIDTH + 4;

   cfg_type         cfg_ff, cfg_in;
   logic            q_push, q_pop, q_full, q_valid;
   logic [QW-1:0]   q_wdata, q_rdata;
   back_status_type bst;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KP:    cfg_in.kp    = csr_wdata[GAIN_W-1:0];
            CSR_KI:    cfg_in.ki    = csr_wdata[GAIN_W-1:0];
            CSR_KD:    cfg_in.kd    = csr_wdata[GAIN_W-1:0];
            CSR_LIMIT: cfg_in.limit = csr_wdata[LIMIT_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp    <= KP_RESET;
         cfg_ff.ki    <= KI_RESET;
         cfg_ff.kd    <= KD_RESET;
         cfg_ff.limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   pcic_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   // decoupling queue
   pcic_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_rdata),
      .pop        (q_pop)
   );

   // back end
   pcic_back #(
      .DATA_WIDTH     (DATA_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .rsp     (rsp),
      .status  (bst)
   );

   // checks
   `PCIC_CHECK_NOW(a_idle_after_reset, $past(reset), !rsp.valid)
   `PCIC_CHECK_NEXT(a_integral_held_in_stall, !bst.advance, $stable(bst.integral))
   `PCIC_CHECK_NOW(a_clear_gives_zero, rsp.valid && bst.out_clear, rsp.drive == '0)

endmodule

>>> tb/pid_position_clamped_integral_core_tb.sv
// self-checking testbench for the positional pid core with clamped integral
`timescale 1ns / 1ps

module pid_position_clamped_integral_core_tb;
   import pcic_pkg::*;

   localparam int DW          = DATA_WIDTH_DEF;
   localparam int RSP_LATENCY = 3;
   localparam int ITEM_TARGET = 1500;
   localparam int HOLD_CYCLES = 80;

   localparam logic signed [DW-1:0]      Q_MAX     = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0]      Q_MIN     = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};
   localparam logic [LIMIT_W-1:0]        LIMIT_MAX = {LIMIT_W{1'b1}};

   // one directed row: either a register write or an item
   typedef struct packed {
      logic                      is_cfg;
      csr_index_type             reg_sel;
      logic [CSR_DATA_W-1:0]     reg_val;
      logic                      func;
      logic signed [DW-1:0]      setpoint;
      logic signed [DW-1:0]      measurement;
      logic                      check_typed;
      logic signed [DRIVE_W-1:0] exp_drive;
   } stim_row_type;

   typedef struct packed {
      logic                      valid;
      logic signed [DRIVE_W-1:0] drive;
   } typed_drive_type;

   localparam int ROW_COUNT = 26;
   localparam stim_row_type STIM_ROWS [ROW_COUNT] = '{
      // reset gains: kp 563, ki 0, kd 3072
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, 24'sd0, 24'sd0, 1'b1, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, Q_MAX, Q_MIN, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, Q_MIN, Q_MAX, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, Q_MAX, Q_MAX, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_CLEAR, Q_MAX, Q_MIN, 1'b1, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, 24'sd256, 24'sd0, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, -24'sd256, 24'sd0, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, 24'sd1, 24'sd0, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, -24'sd1, 24'sd0, 1'b0, 32'sd0},
      // all gains and limit at their top
      '{1'b1, CSR_KP, 23'd65535, FUNC_STEP, 24'sd0, 24'sd0, 1'b0, 32'sd0},
      '{1'b1, CSR_KI, 23'd65535, FUNC_STEP, 24'sd0, 24'sd0, 1'b0, 32'sd0},
      '{1'b1, CSR_KD, 23'd65535, FUNC_STEP, 24'sd0, 24'sd0, 1'b0, 32'sd0},
      '{1'b1, CSR_LIMIT, LIMIT_MAX, FUNC_STEP, 24'sd0, 24'sd0, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_CLEAR, 24'sd0, 24'sd0, 1'b1, 32'sd0},
      // drive saturates both ways, integral clamps both ways
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, Q_MAX, Q_MIN, 1'b1, DRIVE_MAX},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, Q_MIN, Q_MAX, 1'b1, DRIVE_MIN},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, Q_MAX, Q_MIN, 1'b1, DRIVE_MAX},
      // zero limit keeps the integral at zero
      '{1'b1, CSR_LIMIT, 23'd0, FUNC_STEP, 24'sd0, 24'sd0, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, 24'sd1000, 24'sd0, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, -24'sd5000, 24'sd300, 1'b0, 32'sd0},
      // all gains zero
      '{1'b1, CSR_KP, 23'd0, FUNC_STEP, 24'sd0, 24'sd0, 1'b0, 32'sd0},
      '{1'b1, CSR_KI, 23'd0, FUNC_STEP, 24'sd0, 24'sd0, 1'b0, 32'sd0},
      '{1'b1, CSR_KD, 23'd0, FUNC_STEP, 24'sd0, 24'sd0, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, Q_MAX, Q_MIN, 1'b1, 32'sd0},
      // smallest nonzero limit
      '{1'b1, CSR_LIMIT, 23'd1, FUNC_STEP, 24'sd0, 24'sd0, 1'b0, 32'sd0},
      '{1'b0, CSR_KP, 23'd0, FUNC_STEP, 24'sd512, 24'sd0, 1'b0, 32'sd0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pcic_req_if #(.DATA_WIDTH(DW)) req_ch ();
   pcic_rsp_if                    rsp_ch ();

   pid_position_clamped_integral_core #(
      .DATA_WIDTH     (DW),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS_DEF)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state and register copies
   cfg_type                   model_cfg;
   logic signed [INTEG_W-1:0] integ_sum;
   logic signed [DW:0]        last_err;

   logic signed [DRIVE_W-1:0] drive_q [$];
   typed_drive_type           typed_q [$];

   int fail_count  = 0;
   int rsp_total   = 0;
   int step_count  = 0;
   int clear_count = 0;
   int sat_count   = 0;
   int clamp_count = 0;
   int phase_count = 0;
   int sent_count  = 0;
   bit hold_done   = 1'b0;
   bit tx_quiet    = 1'b0;

   // gain times value, floored back to the value's fraction bits
   function automatic longint gain_floor(logic [GAIN_W-1:0] gain, longint value);
      longint g;
      g = longint'(gain);
      return (g * value) >>> GAIN_FRAC_BITS_DEF;
   endfunction

   // one controller step: updates integral and last error, returns drive
   function automatic logic signed [DRIVE_W-1:0] pid_step_drive(
      logic f, logic signed [DW-1:0] sp, logic signed [DW-1:0] meas);
      longint err, acc, lim, total;
      if (f == FUNC_CLEAR) begin
         integ_sum = '0;
         last_err  = '0;
         clear_count++;
         return '0;
      end
      step_count++;
      err = longint'(sp) - longint'(meas);
      lim = longint'(model_cfg.limit);
      acc = longint'(integ_sum) + gain_floor(model_cfg.ki, err);
      if (acc > lim) begin
         acc = lim;
         clamp_count++;
      end else if (acc < -lim) begin
         acc = -lim;
         clamp_count++;
      end
      integ_sum = acc[INTEG_W-1:0];
      total = gain_floor(model_cfg.kp, err) + acc
            + gain_floor(model_cfg.kd, err - longint'(last_err));
      if (total > longint'(DRIVE_MAX)) begin
         total = longint'(DRIVE_MAX);
         sat_count++;
      end else if (total < longint'(DRIVE_MIN)) begin
         total = longint'(DRIVE_MIN);
         sat_count++;
      end
      last_err = err[DW:0];
      return total[DRIVE_W-1:0];
   endfunction

   // monitor: register writes, input transfers and result checks
   always @(posedge clock) begin
      logic signed [DRIVE_W-1:0] predicted;
      logic signed [DRIVE_W-1:0] wanted;
      typed_drive_type           typed;
      if (reset) begin
         model_cfg = '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET, limit: LIMIT_RESET};
         integ_sum = '0;
         last_err  = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_KP:    model_cfg.kp    = csr_wdata[GAIN_W-1:0];
               CSR_KI:    model_cfg.ki    = csr_wdata[GAIN_W-1:0];
               CSR_KD:    model_cfg.kd    = csr_wdata[GAIN_W-1:0];
               CSR_LIMIT: model_cfg.limit = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            predicted = pid_step_drive(req_ch.func, req_ch.setpoint, req_ch.measurement);
            typed = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
            drive_q.push_back(typed.valid ? typed.drive : predicted);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_total++;
            if (drive_q.size() == 0) begin
               $error("unexpected result transfer: drive %0d", rsp_ch.drive);
               fail_count++;
            end else begin
               wanted = drive_q.pop_front();
               if (rsp_ch.drive !== wanted) begin
                  $error("drive mismatch: expected %0d actual %0d", wanted, rsp_ch.drive);
                  fail_count++;
               end
            end
         end
      end
   end

   // result side: random stalls, plus one long hold-off with the sender still busy
   initial begin
      int stall_left;
      int r;
      bit rx_quiet;
      stall_left = 0;
      rx_quiet   = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_total >= 400 && req_ch.valid) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         if ($urandom_range(0, 99) == 0) rx_quiet = ~rx_quiet;
         r = $urandom_range(0, 99);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else if (rx_quiet) begin
            rsp_ch.ready = 1'b1;
         end else if (r < 3) begin
            stall_left   = $urandom_range(5, 30);
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = (r >= 20);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("** pid_position_clamped_integral_core: FAILED **");
      $finish;
   end

   // sender gap: mostly none or short, a few long
   function automatic int tx_gap();
      int r;
      if (tx_quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // called at a falling edge; returns at a falling edge after the transfer and gap
   task automatic send_item(logic f, logic signed [DW-1:0] sp, logic signed [DW-1:0] meas,
                            logic typed_ok, logic signed [DRIVE_W-1:0] typed_val);
      int gap;
      typed_q.push_back('{valid: typed_ok, drive: typed_val});
      req_ch.valid       = 1'b1;
      req_ch.func        = f;
      req_ch.setpoint    = sp;
      req_ch.measurement = meas;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      sent_count++;
      gap = tx_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // sender stops until every expected result has come back
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (drive_q.size() != 0) @(negedge clock);
      repeat (RSP_LATENCY + 2) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type sel, logic [CSR_DATA_W-1:0] val);
      csr_wr_en = 1'b1;
      csr_index = sel;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return 23'd65535;
      if (r < 5) return CSR_DATA_W'($urandom_range(0, 1024));
      return CSR_DATA_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return LIMIT_MAX;
      if (r < 6) return CSR_DATA_W'($urandom_range(0, 65535));
      return LIMIT_MAX & CSR_DATA_W'($urandom());
   endfunction

   function automatic logic signed [DW-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // stimulus
   initial begin
      longint target, plant;
      logic signed [DW-1:0] sp, meas;
      int phase_len, kind;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_KP;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_STEP;
      req_ch.setpoint    = '0;
      req_ch.measurement = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (int i = 0; i < ROW_COUNT; i++) begin
         if (STIM_ROWS[i].is_cfg) begin
            wait_drained();
            csr_write(STIM_ROWS[i].reg_sel, STIM_ROWS[i].reg_val);
         end else begin
            send_item(STIM_ROWS[i].func, STIM_ROWS[i].setpoint, STIM_ROWS[i].measurement,
                      STIM_ROWS[i].check_typed, STIM_ROWS[i].exp_drive);
         end
      end

      // random phases: new register settings, then a run of items
      target = 0;
      plant  = 0;
      while (sent_count < ITEM_TARGET) begin
         wait_drained();
         phase_count++;
         if (phase_count == 1 || $urandom_range(0, 9) < 7) csr_write(CSR_KP, pick_gain());
         if (phase_count == 1 || $urandom_range(0, 9) < 7) csr_write(CSR_KI, pick_gain());
         if (phase_count == 1 || $urandom_range(0, 9) < 7) csr_write(CSR_KD, pick_gain());
         if (phase_count == 1 || $urandom_range(0, 9) < 7) csr_write(CSR_LIMIT, pick_limit());
         tx_quiet  = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(40, 200);
         for (int n = 0; n < phase_len; n++) begin
            // pause mid-phase in every other phase until the pipe is empty
            if (n == phase_len / 2 && phase_count % 2 == 0) wait_drained();
            kind = $urandom_range(0, 99);
            if (kind < 4) begin
               send_item(FUNC_CLEAR, DW'($urandom()), DW'($urandom()), 1'b0, '0);
            end else if (kind < 14) begin
               send_item(FUNC_STEP, DW'($urandom()), DW'($urandom()), 1'b0, '0);
            end else if (kind < 20) begin
               send_item(FUNC_STEP, pick_extreme(), pick_extreme(), 1'b0, '0);
            end else begin
               // closed-loop style: measurement chases a setpoint that jumps now and then
               if ($urandom_range(0, 29) == 0) target = $signed(DW'($urandom()));
               plant += (target - plant) / 8 + longint'($urandom_range(0, 512)) - 256;
               if (plant > longint'(Q_MAX)) plant = longint'(Q_MAX);
               if (plant < longint'(Q_MIN)) plant = longint'(Q_MIN);
               sp   = target[DW-1:0];
               meas = plant[DW-1:0];
               send_item(FUNC_STEP, sp, meas, 1'b0, '0);
            end
         end
      end

      wait_drained();
      repeat (RSP_LATENCY + 5) @(negedge clock);
      if (drive_q.size() != 0) begin
         $error("%0d expected results never arrived", drive_q.size());
         fail_count++;
      end
      $display("run: %0d steps, %0d clears over %0d random phases, %0d results checked",
               step_count, clear_count, phase_count, rsp_total);
      $display("run: %0d saturated drives, %0d integral clamps, long receiver hold %s",
               sat_count, clamp_count, hold_done ? "done" : "missed");
      if (fail_count == 0) begin
         $display("** pid_position_clamped_integral_core: PASSED **");
      end else begin
         $display("** pid_position_clamped_integral_core: FAILED **");
      end
      $finish;
   end

endmodule
